@@ rtl/psf_pkg.sv @@
// Shared types and constants for the pose smoothing filter.
// Holds payload structs, controller commands and status; no dependencies.
`timescale 1ns / 1ps

package psf_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int BLEND_W    = 17;
    localparam int PROD_W     = WORD_W + BLEND_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int DOT_W      = 2 * WORD_W + 3;
    localparam int SQ_W       = 2 * WORD_W + 2;
    localparam int RAD_W      = 2 * WORD_W;
    localparam int ROOT_W     = WORD_W;
    localparam int NUM_W      = WORD_W + FRAC_W + 1;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;

    localparam logic [BLEND_W-1:0] BLEND_ONE   = 17'h10000;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'h08000;

    typedef struct packed {
        logic                     mode;
        logic signed [WORD_W-1:0] sample_w;
        logic signed [WORD_W-1:0] sample_x;
        logic signed [WORD_W-1:0] sample_y;
        logic signed [WORD_W-1:0] sample_z;
        logic signed [WORD_W-1:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] rot_w;
        logic signed [WORD_W-1:0] rot_x;
        logic signed [WORD_W-1:0] rot_y;
        logic signed [WORD_W-1:0] rot_z;
        logic signed [WORD_W-1:0] time_out;
        logic                     degenerate;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DOT,
        OP_BLEND_NEW,
        OP_BLEND_OLD,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic sq_zero;
        logic out_full;
    } status_t;

endpackage

@@ rtl/pose_smoothing_filter_unit.sv @@
// Pose smoothing filter top level: APB register, controller and datapath.
// Depends on psf_pkg, psf_ctrl and psf_datapath.
// Rotation samples run a 32-step square root and four 49-step divides
// through one shared divider; a degenerate rotation skips both.
// A new sample is accepted only while the controller is idle, after the
// previous result has been written to the output register.
// Reset: position and time zero, rotation identity, blend_factor 0.5.
`timescale 1ns / 1ps

module pose_smoothing_filter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psf_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output psf_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [psf_pkg::BLEND_W-1:0] blend_factor_reg;
    psf_pkg::cmd_t               cmd;
    psf_pkg::status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_factor_reg <= psf_pkg::BLEND_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            blend_factor_reg <= pwdata[psf_pkg::BLEND_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - psf_pkg::BLEND_W){1'b0}}, blend_factor_reg};

    psf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    psf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_data      (in_data),
        .blend_factor (blend_factor_reg),
        .out_ready    (out_ready),
        .status       (status),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );

endmodule

@@ rtl/psf_datapath.sv @@
// Datapath of the pose smoothing filter: pose stores, blend, dot and square
// multipliers, square root and divide iterations, output register. Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  psf_pkg::cmd_t                      cmd,
    input  psf_pkg::in_item_t                  in_data,
    input  logic [psf_pkg::BLEND_W-1:0]        blend_factor,
    input  logic                               out_ready,
    output psf_pkg::status_t                   status,
    output logic                               out_valid,
    output psf_pkg::out_item_t                 out_data
);

    localparam int W  = psf_pkg::WORD_W;
    localparam int FR = psf_pkg::FRAC_W;

    function automatic logic signed [W-1:0] sat_word(input logic signed [psf_pkg::ACC_W-1:0] v);
        logic signed [psf_pkg::ACC_W-1:0] hi;
        logic signed [psf_pkg::ACC_W-1:0] lo;
        hi = (psf_pkg::ACC_W'(1) <<< (W - 1)) - psf_pkg::ACC_W'(1);
        lo = -hi - psf_pkg::ACC_W'(1);
        if (v > hi)
        begin
            return hi[W-1:0];
        end
        else if (v < lo)
        begin
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    psf_pkg::in_item_t              in_reg;
    logic [psf_pkg::BLEND_W-1:0]    f_reg;
    logic signed [W-1:0]            pos_reg [3];
    logic signed [W-1:0]            rot_reg [4];
    logic signed [W-1:0]            mix_reg [4];
    logic signed [W-1:0]            time_reg;
    logic signed [psf_pkg::ACC_W-1:0] acc_reg;
    logic signed [psf_pkg::DOT_W-1:0] dot_reg;
    logic [psf_pkg::SQ_W-1:0]       sq_reg;
    logic [psf_pkg::RAD_W-1:0]      rad_reg;
    logic [psf_pkg::ROOT_W+1:0]     rem_reg;
    logic [psf_pkg::ROOT_W-1:0]     root_reg;
    logic [psf_pkg::NUM_W-1:0]      num_reg;
    logic [psf_pkg::ROOT_W:0]       drem_reg;
    logic                           degen_reg;
    logic                           out_valid_reg;
    psf_pkg::out_item_t             out_reg;

    logic signed [W-1:0]            new_val;
    logic signed [W-1:0]            old_val;
    logic signed [psf_pkg::BLEND_W:0] f_s;
    logic signed [psf_pkg::BLEND_W:0] g_s;
    logic signed [psf_pkg::PROD_W-1:0] p_mul;
    logic signed [psf_pkg::ACC_W-1:0] b_sum;
    logic signed [psf_pkg::ACC_W-1:0] b_shift;
    logic                           neg;
    logic signed [2*W-1:0]          p_dot;
    logic signed [2*W-1:0]          p_sq;
    logic [psf_pkg::ROOT_W+3:0]     rem_sh;
    logic [psf_pkg::ROOT_W+3:0]     trial;
    logic [psf_pkg::ROOT_W+1:0]     dsh;
    logic signed [W-1:0]            mix_sel;
    logic [W-1:0]                   mix_abs;
    logic [psf_pkg::NUM_W-1:0]      q_max;
    logic signed [W-1:0]            q_word;

    always_comb
    begin
        if (in_reg.mode)
        begin
            case (cmd.idx)
                2'd0:    new_val = in_reg.sample_w;
                2'd1:    new_val = in_reg.sample_x;
                2'd2:    new_val = in_reg.sample_y;
                default: new_val = in_reg.sample_z;
            endcase
            old_val = rot_reg[cmd.idx];
        end
        else
        begin
            case (cmd.idx)
                2'd0:    new_val = in_reg.sample_x;
                2'd1:    new_val = in_reg.sample_y;
                default: new_val = in_reg.sample_z;
            endcase
            old_val = (cmd.idx == 2'd3) ? pos_reg[2] : pos_reg[cmd.idx];
        end
    end

    assign f_s     = $signed({1'b0, f_reg});
    assign g_s     = $signed({1'b0, psf_pkg::BLEND_ONE - f_reg});
    assign neg     = in_reg.mode & dot_reg[psf_pkg::DOT_W-1];
    assign p_mul   = (cmd.op == psf_pkg::OP_BLEND_NEW) ? f_s * new_val : g_s * old_val;
    assign b_sum   = (neg ? acc_reg - psf_pkg::ACC_W'(p_mul) : acc_reg + psf_pkg::ACC_W'(p_mul))
                     + (psf_pkg::ACC_W'(1) <<< (FR - 1));
    assign b_shift = b_sum >>> FR;
    assign p_dot   = new_val * rot_reg[cmd.idx];
    assign mix_sel = mix_reg[cmd.idx];
    assign p_sq    = mix_sel * mix_sel;
    assign mix_abs = mix_sel[W-1] ? W'(-mix_sel) : W'(mix_sel);
    assign rem_sh  = {rem_reg, rad_reg[psf_pkg::RAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign dsh     = {drem_reg, num_reg[psf_pkg::NUM_W-1]};
    assign q_max   = psf_pkg::NUM_W'(1) << (W - 1);

    always_comb
    begin
        if (mix_sel[W-1])
        begin
            q_word = (num_reg > q_max) ? {1'b1, {(W-1){1'b0}}} : W'(-num_reg);
        end
        else
        begin
            q_word = (num_reg >= q_max) ? {1'b0, {(W-1){1'b1}}} : W'(num_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            pos_reg[2]    <= '0;
            rot_reg[0]    <= W'(1) << FR;
            rot_reg[1]    <= '0;
            rot_reg[2]    <= '0;
            rot_reg[3]    <= '0;
            time_reg      <= '0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (cmd.op == psf_pkg::OP_EMIT) | (out_valid_reg & ~out_ready);
            unique case (cmd.op)
                psf_pkg::OP_LOAD:
                begin
                    in_reg    <= in_data;
                    f_reg     <= (blend_factor > psf_pkg::BLEND_ONE) ? psf_pkg::BLEND_ONE
                                                                     : blend_factor;
                    time_reg  <= in_data.sample_time;
                    degen_reg <= 1'b0;
                end
                psf_pkg::OP_DOT:
                begin
                    dot_reg <= ((cmd.idx == 2'd0) ? '0 : dot_reg) + psf_pkg::DOT_W'(p_dot);
                end
                psf_pkg::OP_BLEND_NEW:
                begin
                    acc_reg <= psf_pkg::ACC_W'(p_mul);
                end
                psf_pkg::OP_BLEND_OLD:
                begin
                    if (in_reg.mode)
                    begin
                        mix_reg[cmd.idx] <= sat_word(b_shift);
                    end
                    else if (cmd.idx != 2'd3)
                    begin
                        pos_reg[cmd.idx] <= sat_word(b_shift);
                    end
                end
                psf_pkg::OP_SQ:
                begin
                    sq_reg <= ((cmd.idx == 2'd0) ? '0 : sq_reg)
                              + psf_pkg::SQ_W'($unsigned(p_sq));
                end
                psf_pkg::OP_SQRT_INIT:
                begin
                    rad_reg  <= (sq_reg[psf_pkg::SQ_W-1 -: 2] != 2'b00) ? '1
                                                                         : sq_reg[psf_pkg::RAD_W-1:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                    if (sq_reg == '0)
                    begin
                        degen_reg <= 1'b1;
                    end
                end
                psf_pkg::OP_SQRT_STEP:
                begin
                    rad_reg <= rad_reg << 2;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= (psf_pkg::ROOT_W+2)'(rem_sh - trial);
                        root_reg <= {root_reg[psf_pkg::ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[psf_pkg::ROOT_W+1:0];
                        root_reg <= {root_reg[psf_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
                psf_pkg::OP_DIV_INIT:
                begin
                    num_reg  <= psf_pkg::NUM_W'({mix_abs, {FR{1'b0}}})
                                + psf_pkg::NUM_W'(root_reg >> 1);
                    drem_reg <= '0;
                end
                psf_pkg::OP_DIV_STEP:
                begin
                    if (dsh >= {2'b00, root_reg})
                    begin
                        drem_reg <= (psf_pkg::ROOT_W+1)'(dsh - {2'b00, root_reg});
                        num_reg  <= {num_reg[psf_pkg::NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh[psf_pkg::ROOT_W:0];
                        num_reg  <= {num_reg[psf_pkg::NUM_W-2:0], 1'b0};
                    end
                end
                psf_pkg::OP_DIV_STORE:
                begin
                    rot_reg[cmd.idx] <= q_word;
                end
                psf_pkg::OP_EMIT:
                begin
                    out_reg.pos_x      <= pos_reg[0];
                    out_reg.pos_y      <= pos_reg[1];
                    out_reg.pos_z      <= pos_reg[2];
                    out_reg.rot_w      <= rot_reg[0];
                    out_reg.rot_x      <= rot_reg[1];
                    out_reg.rot_y      <= rot_reg[2];
                    out_reg.rot_z      <= rot_reg[3];
                    out_reg.time_out   <= time_reg;
                    out_reg.degenerate <= degen_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.mode     = in_reg.mode;
    assign status.sq_zero  = (sq_reg == '0);
    assign status.out_full = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

@@ rtl/psf_ctrl.sv @@
// Controller of the pose smoothing filter: sequences the datapath steps.
// Depends on psf_pkg for command and status types.
`timescale 1ns / 1ps

module psf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  psf_pkg::status_t status,
    output psf_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DOT,
        S_BLEND_NEW,
        S_BLEND_OLD,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 idx_reg, idx_next;
    logic [psf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd.idx    = idx_reg;
        cmd.op     = psf_pkg::OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = psf_pkg::OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                idx_next   = 2'd0;
                state_next = status.mode ? S_DOT : S_BLEND_NEW;
            end
            S_DOT:
            begin
                cmd.op   = psf_pkg::OP_DOT;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_BLEND_NEW;
                end
            end
            S_BLEND_NEW:
            begin
                cmd.op     = psf_pkg::OP_BLEND_NEW;
                state_next = S_BLEND_OLD;
            end
            S_BLEND_OLD:
            begin
                cmd.op   = psf_pkg::OP_BLEND_OLD;
                idx_next = idx_reg + 2'd1;
                if (status.mode && idx_reg == 2'd3)
                begin
                    state_next = S_SQ;
                end
                else if (!status.mode && idx_reg == 2'd2)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_BLEND_NEW;
                end
            end
            S_SQ:
            begin
                cmd.op   = psf_pkg::OP_SQ;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = psf_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = status.sq_zero ? S_EMIT : S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = psf_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == psf_pkg::CNT_W'(psf_pkg::SQRT_STEPS - 1))
                begin
                    idx_next   = 2'd0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = psf_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = psf_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == psf_pkg::CNT_W'(psf_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIV_STORE;
                end
            end
            S_DIV_STORE:
            begin
                cmd.op   = psf_pkg::OP_DIV_STORE;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? S_EMIT : S_DIV_INIT;
            end
            S_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = psf_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
